>>> sv/key_value_table_macros.svh
// Assertion helpers for the key/value table.
// Each expects clk and rst in the scope of use.
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, off during reset.
`define KVT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define KVT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 7;
  localparam int DATA_W   = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [DATA_W-1:0] data_t;

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_KEY  = 2'd1;  // present on insert, absent otherwise
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Control from the sequencer to the entry store
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;      // write key/value and set the valid bit
    idx_t  wr_addr;
    data_t wr_key;
    data_t wr_value;
    logic  clr_en;     // drop one entry
    idx_t  clr_addr;
    logic  clr_all;    // drop every entry
  } store_req_t;

  // Registered read result from the entry store
  typedef struct packed {
    logic  pending;
    idx_t  idx;
    logic  valid;
    data_t key;
    data_t value;
  } store_rsp_t;

endpackage

`default_nettype wire

>>> sv/kvt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module kvt_store (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kvt_pkg::store_req_t req,
  output kvt_pkg::store_rsp_t      rsp
);

  // Key/value memory, one entry per slot
  logic [2*kvt_pkg::DATA_W-1:0] mem [kvt_pkg::CAPACITY];
  logic [kvt_pkg::CAPACITY-1:0] valid;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_key, req.wr_value};
    end
  end

  // Registered read port; valid bit sampled alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.pending <= 1'b0;
    end else begin
      rsp.pending <= req.rd_en;
    end
    if (req.rd_en) begin
      {rsp.key, rsp.value} <= mem[req.rd_addr];
      rsp.valid            <= valid[req.rd_addr];
      rsp.idx              <= req.rd_addr;
    end
  end

  // Per-slot valid bits
  always_ff @(posedge clk) begin
    if (rst || req.clr_all) begin
      valid <= '0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.clr_en) begin
        valid[req.clr_addr] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/key_value_table.sv
// Fixed-capacity map of 32-bit keys to 32-bit values. Each request word carries
// one command (clear, insert, delete, lookup) and yields exactly one response
// word with a status, the looked-up value and the occupancy after the command.
// Insert, delete and lookup walk the slots one per cycle through the single
// read port of the entry memory, stopping at the first match; a clear skips the
// scan. One command is in work at a time: req_ready is high only while the
// sequencer is idle. The response sits in an output register, so a new command
// may start while the previous response waits to be taken. No clearing pass
// follows reset; valid bits are reset.
`timescale 1ns / 1ps
`default_nettype none

`include "key_value_table_macros.svh"

module key_value_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic [1:0]        command,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] value_in,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic [1:0]             status,
  output logic signed [31:0]     value_out,
  output logic [6:0]             occupancy
);

  kvt_pkg::state_t     state, state_next;
  kvt_pkg::store_req_t sreq;
  kvt_pkg::store_rsp_t srsp;

  // Latched command word
  logic [1:0]     cmd_reg;
  kvt_pkg::data_t key_reg;
  kvt_pkg::data_t val_reg;

  // Scan state
  kvt_pkg::idx_t  scan_idx;
  logic           issued_all;
  logic           found;
  kvt_pkg::idx_t  found_idx;
  kvt_pkg::data_t found_value;
  logic           free_found;
  kvt_pkg::idx_t  free_idx;
  kvt_pkg::cnt_t  count;

  // Response register
  logic           rsp_valid_q;
  logic [1:0]     out_status;
  kvt_pkg::data_t out_value;
  kvt_pkg::occ_t  out_occ;

  logic           accept;
  logic           hit;
  logic           scan_end;
  logic           finish;
  logic [1:0]     stat_next;
  kvt_pkg::data_t vout_next;
  kvt_pkg::cnt_t  count_next;

  kvt_store u_store (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  assign req_ready = (state == kvt_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_valid = rsp_valid_q;
  assign status    = out_status;
  assign value_out = out_value;
  assign occupancy = out_occ;

  // Compare stage on the returned slot
  assign hit      = (state == kvt_pkg::S_SCAN) && srsp.pending && srsp.valid &&
                    (srsp.key == key_reg);
  assign scan_end = (state == kvt_pkg::S_SCAN) && srsp.pending &&
                    (hit || (srsp.idx == kvt_pkg::idx_t'(kvt_pkg::CAPACITY - 1)));
  assign finish   = (state == kvt_pkg::S_FINISH) && (!rsp_valid_q || rsp_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kvt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (command == kvt_pkg::CMD_CLEAR) ? kvt_pkg::S_FINISH
                                                       : kvt_pkg::S_SCAN;
        end
      end
      kvt_pkg::S_SCAN: begin
        if (scan_end) state_next = kvt_pkg::S_FINISH;
      end
      kvt_pkg::S_FINISH: begin
        if (finish) state_next = kvt_pkg::S_IDLE;
      end
      default: state_next = kvt_pkg::S_IDLE;
    endcase
  end

  // Result and store control
  always_comb begin
    stat_next     = kvt_pkg::STAT_OK;
    vout_next     = '0;
    count_next    = count;
    sreq          = '0;
    sreq.rd_en    = (state == kvt_pkg::S_SCAN) && !issued_all;
    sreq.rd_addr  = scan_idx;
    sreq.wr_addr  = free_idx;
    sreq.wr_key   = key_reg;
    sreq.wr_value = val_reg;
    sreq.clr_addr = found_idx;
    case (cmd_reg)
      kvt_pkg::CMD_CLEAR: begin
        count_next   = '0;
        sreq.clr_all = finish;
      end
      kvt_pkg::CMD_INSERT: begin
        if (found) begin
          stat_next = kvt_pkg::STAT_KEY;
        end else if (count >= kvt_pkg::cnt_t'(kvt_pkg::CAPACITY) || !free_found) begin
          stat_next = kvt_pkg::STAT_FULL;
        end else begin
          sreq.wr_en = finish;
          count_next = count + kvt_pkg::cnt_t'(1);
        end
      end
      kvt_pkg::CMD_DELETE: begin
        if (found) begin
          sreq.clr_en = finish;
          if (count != '0) count_next = count - kvt_pkg::cnt_t'(1);
        end else begin
          stat_next = kvt_pkg::STAT_KEY;
        end
      end
      kvt_pkg::CMD_LOOKUP: begin
        if (found) vout_next = found_value;
        else       stat_next = kvt_pkg::STAT_KEY;
      end
      default: begin
        stat_next = kvt_pkg::STAT_OK;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kvt_pkg::S_IDLE;
      count       <= '0;
      rsp_valid_q <= 1'b0;
      scan_idx    <= '0;
      issued_all  <= 1'b0;
      found       <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_idx   <= '0;
        issued_all <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (sreq.rd_en) begin
          scan_idx <= scan_idx + kvt_pkg::idx_t'(1);
          if (scan_idx == kvt_pkg::idx_t'(kvt_pkg::CAPACITY - 1)) issued_all <= 1'b1;
        end
        if (hit) found <= 1'b1;
        if ((state == kvt_pkg::S_SCAN) && srsp.pending && !srsp.valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (finish) begin
        count       <= count_next;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg <= command;
      key_reg <= key;
      val_reg <= value_in;
    end
    if (hit) begin
      found_idx   <= srsp.idx;
      found_value <= srsp.value;
    end
    if ((state == kvt_pkg::S_SCAN) && srsp.pending && !srsp.valid && !free_found) begin
      free_idx <= srsp.idx;
    end
    if (finish) begin
      out_status <= stat_next;
      out_value  <= vout_next;
      out_occ    <= kvt_pkg::occ_t'(count_next);
    end
  end

  // Checks
  `KVT_CHECK(a_full_occ, rsp_valid_q && (out_status == kvt_pkg::STAT_FULL), count == kvt_pkg::cnt_t'(kvt_pkg::CAPACITY), "full status with free slots")
  `KVT_CHECK(a_miss_zero, rsp_valid_q && (out_status != kvt_pkg::STAT_OK), out_value == '0, "value on failed command")
  `KVT_CHECK(a_scan_cmd, state == kvt_pkg::S_SCAN, cmd_reg != kvt_pkg::CMD_CLEAR, "scan on clear")
  `KVT_CHECK_NEXT(a_ins_inc, finish && (cmd_reg == kvt_pkg::CMD_INSERT) && (stat_next == kvt_pkg::STAT_OK), count == $past(count) + kvt_pkg::cnt_t'(1), "insert did not count")

endmodule

`default_nettype wire

>>> verif/key_value_table_tb.sv
`timescale 1ns / 1ps

module key_value_table_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;   // longer than the worst scan
  localparam int unsigned HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int unsigned PHASE_WORDS = 345;

  // Expected table contents and the responses still owed by the block
  class kv_scoreboard;
    typedef struct {
      logic [1:0]  status;
      logic [31:0] value;
      logic [6:0]  occ;
    } kv_rsp_t;

    logic [31:0] slot_key[kvt_pkg::CAPACITY];
    logic [31:0] slot_value[kvt_pkg::CAPACITY];
    bit          slot_used[kvt_pkg::CAPACITY];
    int unsigned held;
    int unsigned errors;
    kv_rsp_t     owed_q[$];

    function int find_key(logic [31:0] k);
      for (int i = 0; i < kvt_pkg::CAPACITY; i++) begin
        if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    // Update the table for one accepted command word and queue its response
    function void note_command(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
      kv_rsp_t r;
      int      hit;
      r.status = kvt_pkg::STAT_OK;
      r.value = '0;
      hit = find_key(k);
      case (cmd)
        kvt_pkg::CMD_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          held = 0;
        end
        kvt_pkg::CMD_INSERT: begin
          if (hit >= 0) begin
            r.status = kvt_pkg::STAT_KEY;
          end else if (held >= kvt_pkg::CAPACITY) begin
            r.status = kvt_pkg::STAT_FULL;
          end else begin
            // lowest free slot
            for (int i = 0; i < kvt_pkg::CAPACITY; i++) begin
              if (!slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot_key[i] = k;
                slot_value[i] = v;
                break;
              end
            end
            held++;
          end
        end
        kvt_pkg::CMD_DELETE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            held--;
          end else begin
            r.status = kvt_pkg::STAT_KEY;
          end
        end
        default: begin
          if (hit >= 0) r.value = slot_value[hit];
          else r.status = kvt_pkg::STAT_KEY;
        end
      endcase
      r.occ = held[6:0];
      owed_q.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic [31:0] v, logic [6:0] occ);
      kv_rsp_t r;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected response status=%0d value=%h occupancy=%0d",
                   $realtime, st, v, occ);
        return;
      end
      r = owed_q.pop_front();
      if (st !== r.status || v !== r.value || occ !== r.occ) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp status=%0d value=%h occupancy=%0d, got status=%0d value=%h occupancy=%0d",
                   $realtime, r.status, r.value, r.occ, st, v, occ);
      end
    endfunction

    // A key currently stored, chosen at random; a random key when the table is empty
    function logic [31:0] stored_key();
      int pick;
      if (held == 0) return $urandom;
      pick = $urandom_range(held - 1);
      for (int i = 0; i < kvt_pkg::CAPACITY; i++) begin
        if (slot_used[i]) begin
          if (pick == 0) return slot_key[i];
          pick--;
        end
      end
      return $urandom;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  command = kvt_pkg::CMD_CLEAR;
  logic [31:0] key = '0;
  logic [31:0] value_in = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [6:0]  occupancy;

  kv_scoreboard sb = new;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_left = 0;
  int unsigned  cycle_count = 0;
  bit           hold_req = 1'b0;
  bit           hold_taken = 1'b0;

  key_value_table DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .command(command),
    .key(key),
    .value_in(value_in),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .status(status),
    .value_out(value_out),
    .occupancy(occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_value_table_tb: errors");
      $finish;
    end
  end

  // Response side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_response(status, value_out, occupancy);
  end

  // Offer one request word; entered and left at a falling edge
  task automatic send_word(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    key <= k;
    value_in <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_command(cmd, k, v);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50 && sb.held > 0) return sb.stored_key();
    if (r < 55) return 32'h8000_0000;
    if (r < 60) return 32'h7fff_ffff;
    if (r < 63) return 32'hffff_ffff;
    if (r < 65) return 32'h0000_0000;
    return $urandom;
  endfunction

  // Fill to capacity, push past it, then a random command mix
  task automatic run_phase(int unsigned words, bit with_hold);
    int unsigned sent;
    int unsigned r;
    logic [1:0]  cmd;
    sent = 0;
    send_word(kvt_pkg::CMD_CLEAR, $urandom, $urandom);
    while (sb.held < kvt_pkg::CAPACITY) begin
      send_word(kvt_pkg::CMD_INSERT, $urandom, $urandom);
      sent++;
    end
    send_word(kvt_pkg::CMD_INSERT, $urandom, $urandom);   // full
    send_word(kvt_pkg::CMD_INSERT, sb.stored_key(), $urandom);   // duplicate on a full table
    send_word(kvt_pkg::CMD_LOOKUP, sb.stored_key(), $urandom);
    sent += 4;
    if (with_hold) hold_req = 1'b1;
    while (sent < words) begin
      r = $urandom_range(99);
      if (r < 2) cmd = kvt_pkg::CMD_CLEAR;
      else if (r < 37) cmd = kvt_pkg::CMD_INSERT;
      else if (r < 67) cmd = kvt_pkg::CMD_DELETE;
      else cmd = kvt_pkg::CMD_LOOKUP;
      send_word(cmd, random_key(), $urandom);
      sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, every command, duplicates, misses, negative keys
    send_word(kvt_pkg::CMD_CLEAR, 32'h0, 32'h0);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h0, 32'hffff_ffff);          // miss on empty table
    send_word(kvt_pkg::CMD_DELETE, 32'h5, 32'h0);                  // miss on empty table
    send_word(kvt_pkg::CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(kvt_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(kvt_pkg::CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    send_word(kvt_pkg::CMD_INSERT, 32'h0, 32'h0);
    send_word(kvt_pkg::CMD_INSERT, 32'hffff_ffff, 32'h0000_007b);  // duplicate
    send_word(kvt_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'h0);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h7fff_ffff, 32'h0);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h0, 32'hffff_ffff);
    send_word(kvt_pkg::CMD_LOOKUP, 32'hffff_fffe, 32'h0);          // negative miss
    send_word(kvt_pkg::CMD_DELETE, 32'hffff_ffff, 32'h0);
    send_word(kvt_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'h0);
    send_word(kvt_pkg::CMD_DELETE, 32'hffff_ffff, 32'h0);          // already gone
    send_word(kvt_pkg::CMD_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5);  // reuses freed slot
    send_word(kvt_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'h0);
    send_word(kvt_pkg::CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h0, 32'h0);                  // gone after clear
    send_word(kvt_pkg::CMD_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h5555_5555, 32'h0);
    send_word(kvt_pkg::CMD_DELETE, 32'h5555_5555, 32'h0);

    // Random: sender/receiver idle mixes, then no idling at all
    send_idle_pct = 16;
    recv_idle_pct = 61;
    run_phase(PHASE_WORDS, 1'b1);
    send_idle_pct = 61;
    recv_idle_pct = 16;
    run_phase(PHASE_WORDS, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_WORDS, 1'b0);
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("key_value_table_tb: clean");
    end else begin
      $display("key_value_table_tb: errors");
    end
    $finish;
  end

endmodule
